// ===== hdl/sbmq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbmq_pkg
// Shared types and constants for the shared-buffer multi-queue core.
// ----------------------------------------------------------------------------
package sbmq_pkg;

    localparam int DATA_W = 32;
    localparam int QID_W  = 2;
    localparam int STAT_W = 2;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd2;

    localparam logic [DATA_W-1:0] UNDERFLOW_WORD = '1;  // -1

    // Stage strobes from the controller to the datapath.
    typedef struct packed {
        logic accept;   // input word taken this cycle
        logic enq_fin;  // finish enqueue, load result
        logic deq_rd;   // dequeue: read link/data at queue head
        logic deq_fin;  // finish dequeue, load result
    } t_cmd;

    // Datapath status back to the controller.
    typedef struct packed {
        logic out_busy; // result register full and not taken this cycle
    } t_sts;

endpackage
`default_nettype wire

// ===== hdl/shared_buffer_multi_queue_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Steps: enqueue runs a finish step after acceptance, dequeue a read step
//   and then a finish step; a finish step waits while the result register
//   is stalled. A new word is taken only once the previous one has finished;
//   dequeue reads the head pointer before addressing link/data memories.
// Reset (sync, active low): queues empty, free list = slots 0..DEPTH-1 in
//   order via a fill mark, so no clearing pass is needed.
// ----------------------------------------------------------------------------
// shared_buffer_multi_queue_core
// QUEUES FIFO queues sharing a DEPTH-slot buffer, chained through a per-slot
// link store that also carries the free list.
// ----------------------------------------------------------------------------
module shared_buffer_multi_queue_core
    import sbmq_pkg::*;
#(
    parameter int DEPTH  = 16,     // 2 .. 4096 slots
    parameter int QUEUES = 4       // 1 .. 4 queues
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    // request channel
    input  wire logic                     i_valid,
    output logic                          o_stall,
    input  wire logic                     i_func,      // 0 enqueue, 1 dequeue
    input  wire logic [QID_W-1:0]         i_queue_id,
    input  wire logic signed [DATA_W-1:0] i_enq_data,
    // result channel
    output logic                          o_valid,
    input  wire logic                     i_stall,
    output logic signed [DATA_W-1:0]      o_deq_data,
    output logic [STAT_W-1:0]             o_status
);

    t_cmd              cmd;
    t_sts              sts;
    logic [DATA_W-1:0] deq_data;

    // Sequencer: IDLE accepts a word; enqueue then finishes, dequeue
    // goes through one read step first. Finish steps wait while the result
    // register is held by a downstream stall. A new word is accepted while
    // the previous result still waits downstream.
    sbmq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_func  (i_func),
        .i_sts   (sts),
        .o_stall (o_stall),
        .o_cmd   (cmd)
    );

    // Datapath: link/data memories, head/tail tables with head valid bits,
    // free-list head and the result register.
    sbmq_dpath #(
        .DEPTH  (DEPTH),
        .QUEUES (QUEUES)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_func     (i_func),
        .i_queue_id (i_queue_id),
        .i_enq_data (i_enq_data),
        .i_stall    (i_stall),
        .o_valid    (o_valid),
        .o_deq_data (deq_data),
        .o_status   (o_status)
    );

    assign o_deq_data = deq_data;

endmodule
`default_nettype wire

// ===== hdl/sbmq_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbmq_ctrl
// Sequencer: walks each word through its enqueue or dequeue steps.
// ----------------------------------------------------------------------------
module sbmq_ctrl
    import sbmq_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    input  wire logic i_func,
    input  wire t_sts i_sts,
    output logic      o_stall,
    output t_cmd      o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE    = 4'b0001,
        S_ENQ_FIN = 4'b0010,
        S_DEQ_RD  = 4'b0100,
        S_DEQ_FIN = 4'b1000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = i_func ? S_DEQ_RD : S_ENQ_FIN;
                end
            end
            S_ENQ_FIN: begin
                if (!i_sts.out_busy) begin
                    o_cmd.enq_fin = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            S_DEQ_RD: begin
                o_cmd.deq_rd = 1'b1;
                n_state      = S_DEQ_FIN;
            end
            S_DEQ_FIN: begin
                if (!i_sts.out_busy) begin
                    o_cmd.deq_fin = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_stall = (r_state != S_IDLE);

endmodule
`default_nettype wire

// ===== hdl/sbmq_dpath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbmq_dpath
// Slot data, link store, queue head/tail tables, free head and result reg.
// ----------------------------------------------------------------------------
module sbmq_dpath
    import sbmq_pkg::*;
#(
    parameter int DEPTH  = 16,
    parameter int QUEUES = 4
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cmd               i_cmd,
    output t_sts                    o_sts,
    input  wire logic               i_func,
    input  wire logic [QID_W-1:0]   i_queue_id,
    input  wire logic [DATA_W-1:0]  i_enq_data,
    input  wire logic               i_stall,
    output logic                    o_valid,
    output logic [DATA_W-1:0]       o_deq_data,
    output logic [STAT_W-1:0]       o_status
);

    localparam int AW = $clog2(DEPTH);
    localparam int LW = $clog2(DEPTH + 1);          // holds DEPTH as null
    localparam int QW = (QUEUES > 1) ? $clog2(QUEUES) : 1;
    localparam logic [LW-1:0] NULL_LINK = LW'(DEPTH);

    // memories
    logic [DATA_W-1:0] r_data_mem [DEPTH];
    logic [LW-1:0]     r_lnk_mem  [DEPTH];
    logic [LW-1:0]     r_head_mem [QUEUES];
    logic [LW-1:0]     r_tail_mem [QUEUES];
    logic [QUEUES-1:0] r_head_vld;

    // control/pointer state
    logic [LW-1:0]     r_free;
    logic [LW-1:0]     r_fill;     // slots below this have a written link
    logic [QW-1:0]     r_q;
    logic              r_q_ok;
    logic              r_enq_go;
    logic              r_deq_go;
    logic [AW-1:0]     r_slot;

    // registered read data
    logic [LW-1:0]     r_head_rd;
    logic              r_head_rd_vld;
    logic [LW-1:0]     r_tail_rd;
    logic [LW-1:0]     r_lnk_rd;
    logic              r_lnk_ovr;
    logic [LW-1:0]     r_lnk_alt;
    logic [DATA_W-1:0] r_dq_rd;

    // result register
    logic              r_out_vld;
    logic [DATA_W-1:0] r_out_data;
    logic [STAT_W-1:0] r_out_status;

    logic              q_ok;
    logic [QW-1:0]     q_idx;
    logic              free_ok;
    logic              enq_go;
    logic              head_ok;
    logic              tail_ok;
    logic              deq_go;
    logic [LW-1:0]     lnk_val;

    logic              lnk_we;
    logic [AW-1:0]     lnk_wa;
    logic [LW-1:0]     lnk_wd;
    logic              lnk_re;
    logic [AW-1:0]     lnk_ra;

    logic              head_we;
    logic [LW-1:0]     head_wd;

    logic              out_load;
    logic [DATA_W-1:0] out_data;
    logic [STAT_W-1:0] out_status;

    assign q_ok    = (32'(i_queue_id) < QUEUES);
    assign q_idx   = q_ok ? QW'(i_queue_id) : '0;
    assign free_ok = (r_free < NULL_LINK);
    assign enq_go  = !i_func && q_ok && free_ok;

    assign head_ok = r_head_rd_vld && (r_head_rd < NULL_LINK);
    assign tail_ok = (r_tail_rd < NULL_LINK);
    assign deq_go  = r_q_ok && head_ok;
    // untouched slots read as their reset link i+1
    assign lnk_val = r_lnk_ovr ? r_lnk_alt : r_lnk_rd;

    // link store: one read and one write per cycle
    always_comb begin
        lnk_we = 1'b0;
        lnk_wa = r_free[AW-1:0];
        lnk_wd = NULL_LINK;
        lnk_re = 1'b0;
        lnk_ra = r_free[AW-1:0];
        if (i_cmd.accept && enq_go) begin
            // fetch next free, terminate new slot
            lnk_we = 1'b1;
            lnk_re = 1'b1;
        end else if (i_cmd.enq_fin && r_enq_go && head_ok && tail_ok) begin
            lnk_we = 1'b1;
            lnk_wa = r_tail_rd[AW-1:0];
            lnk_wd = LW'(r_slot);
        end else if (i_cmd.deq_rd && deq_go) begin
            // fetch successor, push slot onto free list
            lnk_we = 1'b1;
            lnk_wa = r_head_rd[AW-1:0];
            lnk_wd = r_free;
            lnk_re = 1'b1;
            lnk_ra = r_head_rd[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (lnk_we) begin
            r_lnk_mem[lnk_wa] <= lnk_wd;
        end
        if (lnk_re) begin
            r_lnk_rd  <= r_lnk_mem[lnk_ra];
            r_lnk_ovr <= (LW'(lnk_ra) >= r_fill);
            r_lnk_alt <= LW'(lnk_ra) + LW'(1);
        end
    end

    // slot data
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && enq_go) begin
            r_data_mem[r_free[AW-1:0]] <= i_enq_data;
        end
        if (i_cmd.deq_rd) begin
            r_dq_rd <= r_data_mem[r_head_rd[AW-1:0]];
        end
    end

    // head/tail tables
    always_comb begin
        head_we = 1'b0;
        head_wd = LW'(r_slot);
        if (i_cmd.enq_fin && r_enq_go && !head_ok) begin
            head_we = 1'b1;
        end else if (i_cmd.deq_fin && r_deq_go) begin
            head_we = 1'b1;
            head_wd = lnk_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (head_we) begin
            r_head_mem[r_q] <= head_wd;
        end
        if (i_cmd.enq_fin && r_enq_go) begin
            r_tail_mem[r_q] <= LW'(r_slot);
        end
        if (i_cmd.accept) begin
            r_head_rd <= r_head_mem[q_idx];
            r_tail_rd <= r_tail_mem[q_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_vld    <= '0;
            r_head_rd_vld <= 1'b0;
        end else begin
            if (head_we) begin
                r_head_vld[r_q] <= 1'b1;
            end
            if (i_cmd.accept) begin
                r_head_rd_vld <= r_head_vld[q_idx];
            end
        end
    end

    // free head, fill mark, item context
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free   <= '0;
            r_fill   <= '0;
            r_enq_go <= 1'b0;
            r_deq_go <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_enq_go <= enq_go;
                if (enq_go && (r_free >= r_fill)) begin
                    r_fill <= r_free + LW'(1);
                end
            end
            if (i_cmd.enq_fin && r_enq_go) begin
                r_free <= lnk_val;
            end
            if (i_cmd.deq_rd) begin
                r_deq_go <= deq_go;
                if (deq_go) begin
                    r_free <= r_head_rd;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_q    <= q_idx;
            r_q_ok <= q_ok;
            r_slot <= r_free[AW-1:0];
        end
    end

    // result register
    always_comb begin
        out_load   = i_cmd.enq_fin || i_cmd.deq_fin;
        out_data   = '0;
        out_status = ST_OK;
        if (i_cmd.enq_fin) begin
            out_status = r_enq_go ? ST_OK : ST_OVERFLOW;
        end else if (r_deq_go) begin
            out_data = r_dq_rd;
        end else begin
            out_data   = UNDERFLOW_WORD;
            out_status = ST_UNDERFLOW;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_load) begin
            r_out_vld <= 1'b1;
        end else if (!i_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data   <= out_data;
            r_out_status <= out_status;
        end
    end

    assign o_sts.out_busy = r_out_vld && i_stall;
    assign o_valid        = r_out_vld;
    assign o_deq_data     = r_out_data;
    assign o_status       = r_out_status;

endmodule
`default_nettype wire
